[sv/rlsf_pkg.sv]
// ----------------------------------------------------------------------------
// rlsf_pkg - shared types and constants of the RGB LED strip frame sender
// Item codes, status codes, register map, and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package rlsf_pkg;

	localparam int MAX_PIXELS = 1024;
	localparam int PIX_AW     = $clog2(MAX_PIXELS);
	localparam int LEN_W      = PIX_AW + 1;
	localparam int CNT_W      = 16;
	localparam int PIX_W      = 24;
	localparam int CFG_AW     = 4;
	localparam int CFG_DW     = 32;

	localparam logic [CNT_W-1:0] LATCH_HOLD_RST = 16'd1000;
	localparam logic [CNT_W-1:0] CNT_MAX        = 16'hFFFF;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_CLEAR = 2'd1,
		FN_SEND  = 2'd2,
		FN_TICK  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_STRIP_LENGTH   = 2'd0,
		REG_AUTO_SEND      = 2'd1,
		REG_REFRESH_PERIOD = 2'd2,
		REG_LATCH_HOLD     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] used_len;
		logic             auto_send;
		logic [CNT_W-1:0] refresh_period;
		logic [CNT_W-1:0] latch_hold;
	} cfg_t;

	typedef struct packed {
		logic sweep;     // clear one pixel memory entry
		logic clr_done;  // finish a clear item after its sweep
		logic exec;      // execute the accepted item
		logic rd;        // read the current pixel
		logic bit_done;  // finish a first-half tick with the read data
	} cmd_t;

	typedef struct packed {
		logic frame_active;
		logic latch_phase;
		logic half_phase;
		logic sweep_last;
		logic out_valid;
	} sts_t;

endpackage

[sv/rlsf_req_if.sv]
// ----------------------------------------------------------------------------
// rlsf_req_if - item channel
// Valid/ready channel carrying one item: function code, pixel index, colour.
// ----------------------------------------------------------------------------
interface rlsf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [9:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, func, pixel_index, red, green, blue, input ready);
	modport sink   (input valid, func, pixel_index, red, green, blue, output ready);
endinterface

[sv/rlsf_rsp_if.sv]
// ----------------------------------------------------------------------------
// rlsf_rsp_if - result channel
// Valid/ready channel carrying one result: line levels, status, sending flag.
// ----------------------------------------------------------------------------
interface rlsf_rsp_if;
	logic       valid;
	logic       ready;
	logic       clock_line;
	logic       data_line;
	logic [1:0] status;
	logic       sending;

	modport source (output valid, clock_line, data_line, status, sending, input ready);
	modport sink   (input valid, clock_line, data_line, status, sending, output ready);
endinterface

[sv/rlsf_regs.sv]
// ----------------------------------------------------------------------------
// rlsf_regs - configuration registers
// APB-style register file; pready is tied high, writes land on the access
// cycle. Also clamps the strip length to the buffer depth.
// ----------------------------------------------------------------------------
module rlsf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rlsf_pkg::CFG_AW-1:0]  paddr,
	input  logic [rlsf_pkg::CFG_DW-1:0]  pwdata,
	output logic [rlsf_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	output rlsf_pkg::cfg_t               cfg,
	output logic                         refresh_wr
);
	import rlsf_pkg::*;

	logic [LEN_W-1:0] strip_length_q;
	logic             auto_send_q;
	logic [CNT_W-1:0] refresh_period_q;
	logic [CNT_W-1:0] latch_hold_q;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_length_q   <= '0;
			auto_send_q      <= 1'b0;
			refresh_period_q <= '0;
			latch_hold_q     <= LATCH_HOLD_RST;
		end else if (wr_en) begin
			case (idx)
				REG_STRIP_LENGTH:   strip_length_q   <= pwdata[LEN_W-1:0];
				REG_AUTO_SEND:      auto_send_q      <= pwdata[0];
				REG_REFRESH_PERIOD: refresh_period_q <= pwdata[CNT_W-1:0];
				REG_LATCH_HOLD:     latch_hold_q     <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_STRIP_LENGTH:   prdata = CFG_DW'(strip_length_q);
			REG_AUTO_SEND:      prdata = CFG_DW'(auto_send_q);
			REG_REFRESH_PERIOD: prdata = CFG_DW'(refresh_period_q);
			REG_LATCH_HOLD:     prdata = CFG_DW'(latch_hold_q);
			default:            prdata = '0;
		endcase
	end

	assign refresh_wr         = wr_en && (idx == REG_REFRESH_PERIOD);
	assign cfg.used_len       = (strip_length_q > LEN_W'(MAX_PIXELS)) ?
	                            LEN_W'(MAX_PIXELS) : strip_length_q;
	assign cfg.auto_send      = auto_send_q;
	assign cfg.refresh_period = refresh_period_q;
	assign cfg.latch_hold     = latch_hold_q;

endmodule

[sv/rlsf_ctrl.sv]
// ----------------------------------------------------------------------------
// rlsf_ctrl - sequencing controller
// Decides per accepted item whether it completes directly, needs a pixel
// read first, or needs a sweep of the pixel memory; drives the datapath.
// ----------------------------------------------------------------------------
module rlsf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          req_func,
	input  logic                rsp_ready,
	input  rlsf_pkg::sts_t      sts,
	output logic                req_ready,
	output rlsf_pkg::cmd_t      cmd
);
	import rlsf_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_READ  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	func_t  func;

	assign func = func_t'(req_func);

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		pend_d    = pend_q;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					cmd.clr_done = pend_q;
					pend_d       = 1'b0;
					state_d      = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = !sts.out_valid || rsp_ready;
				if (req_valid && req_ready) begin
					if (func == FN_TICK && sts.frame_active && !sts.latch_phase &&
					    !sts.half_phase) begin
						cmd.rd  = 1'b1;
						state_d = S_READ;
					end else if (func == FN_CLEAR && !sts.frame_active) begin
						pend_d  = 1'b1;
						state_d = S_CLEAR;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.bit_done = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Start in a sweep so every valid bit is cleared after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

[sv/rlsf_dp.sv]
// ----------------------------------------------------------------------------
// rlsf_dp - frame datapath
// Pixel memory with a valid bit per entry, serializer counters, latch and
// refresh counters, line levels and the result register.
// ----------------------------------------------------------------------------
module rlsf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rlsf_pkg::cmd_t              cmd,
	input  rlsf_pkg::cfg_t              cfg,
	input  logic                        refresh_wr,
	input  logic [1:0]                  req_func,
	input  logic [rlsf_pkg::PIX_AW-1:0] req_pixel_index,
	input  logic [7:0]                  req_red,
	input  logic [7:0]                  req_green,
	input  logic [7:0]                  req_blue,
	input  logic                        rsp_ready,
	output logic                        rsp_valid,
	output logic                        rsp_clock_line,
	output logic                        rsp_data_line,
	output logic [1:0]                  rsp_status,
	output logic                        rsp_sending,
	output rlsf_pkg::sts_t              sts
);
	import rlsf_pkg::*;

	// bit PIX_W is the valid flag of the entry
	logic [PIX_W:0] mem [MAX_PIXELS];
	logic [PIX_W:0] rd_q;

	logic             fa_q, fa_d;
	logic             lat_q, lat_d;
	logic [LEN_W-1:0] pix_q, pix_d;
	logic [1:0]       col_q, col_d;
	logic [2:0]       bit_q, bit_d;
	logic             half_q, half_d;
	logic [CNT_W-1:0] lcnt_q, lcnt_d;
	logic [CNT_W-1:0] idle_q, idle_d;
	logic             clk_q, clk_d;
	logic             dat_q, dat_d;
	status_t          status_q, status_d;
	logic             out_valid_q;
	logic [PIX_AW-1:0] sweep_q;

	logic              load;
	logic              do_start;
	logic              mem_we;
	logic [PIX_AW-1:0] mem_waddr;
	logic [PIX_W:0]    mem_wdata;
	logic [CNT_W-1:0]  idle_inc;
	logic [CNT_W-1:0]  lcnt_dec;
	logic [LEN_W-1:0]  pix_inc;
	logic [7:0]        cur_byte;
	logic              cur_bit;
	func_t             func;

	assign func     = func_t'(req_func);
	assign idle_inc = (idle_q != CNT_MAX) ? idle_q + 16'd1 : idle_q;
	assign lcnt_dec = (lcnt_q != '0) ? lcnt_q - 16'd1 : lcnt_q;
	assign pix_inc  = pix_q + LEN_W'(1);

	always_comb begin
		case (col_q)
			2'd0:    cur_byte = rd_q[23:16];
			2'd1:    cur_byte = rd_q[15:8];
			2'd2:    cur_byte = rd_q[7:0];
			default: cur_byte = 8'h00;
		endcase
	end
	assign cur_bit = rd_q[PIX_W] & cur_byte[3'd7 - bit_q];

	always_comb begin
		fa_d     = fa_q;
		lat_d    = lat_q;
		pix_d    = pix_q;
		col_d    = col_q;
		bit_d    = bit_q;
		half_d   = half_q;
		lcnt_d   = lcnt_q;
		idle_d   = idle_q;
		clk_d    = clk_q;
		dat_d    = dat_q;
		status_d = status_q;
		load     = 1'b0;
		do_start = 1'b0;
		mem_we   = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = '0;

		if (cmd.sweep) begin
			mem_we = 1'b1;
		end

		if (cmd.exec) begin
			load     = 1'b1;
			status_d = ST_OK;
			if (func == FN_TICK) begin
				if (fa_q && lat_q) begin
					clk_d  = 1'b0;
					lcnt_d = lcnt_dec;
					if (lcnt_dec == '0) begin
						fa_d   = 1'b0;
						lat_d  = 1'b0;
						idle_d = '0;
					end
				end else if (fa_q) begin
					// second half of a bit: raise clock and advance
					clk_d  = 1'b1;
					half_d = 1'b0;
					bit_d  = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (col_q == 2'd2) begin
							col_d = 2'd0;
							pix_d = pix_inc;
							if (pix_inc >= cfg.used_len) begin
								lat_d  = 1'b1;
								lcnt_d = cfg.latch_hold;
							end
						end else begin
							col_d = col_q + 2'd1;
						end
					end
				end else if (cfg.refresh_period != '0) begin
					idle_d = idle_inc;
					if (idle_inc >= cfg.refresh_period) do_start = 1'b1;
				end
			end else if (fa_q) begin
				status_d = ST_BUSY;
			end else begin
				case (func)
					FN_WRITE: begin
						if ({1'b0, req_pixel_index} >= cfg.used_len) begin
							status_d = ST_RANGE;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = req_pixel_index;
							mem_wdata = {1'b1, req_red, req_green, req_blue};
							do_start  = cfg.auto_send;
						end
					end
					FN_SEND: do_start = 1'b1;
					default: do_start = cfg.auto_send;
				endcase
			end
		end

		if (cmd.bit_done) begin
			load     = 1'b1;
			status_d = ST_OK;
			clk_d    = 1'b0;
			dat_d    = cur_bit;
			half_d   = 1'b1;
		end

		if (cmd.clr_done) begin
			load     = 1'b1;
			status_d = ST_OK;
			do_start = cfg.auto_send;
		end

		if (do_start) begin
			fa_d   = 1'b1;
			pix_d  = '0;
			col_d  = '0;
			bit_d  = '0;
			half_d = 1'b0;
			idle_d = '0;
			lat_d  = (cfg.used_len == '0);
			lcnt_d = cfg.latch_hold;
		end

		if (refresh_wr) idle_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_q        <= 1'b0;
			lat_q       <= 1'b0;
			pix_q       <= '0;
			col_q       <= '0;
			bit_q       <= '0;
			half_q      <= 1'b0;
			lcnt_q      <= '0;
			idle_q      <= '0;
			clk_q       <= 1'b0;
			dat_q       <= 1'b0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
			sweep_q     <= '0;
		end else begin
			fa_q     <= fa_d;
			lat_q    <= lat_d;
			pix_q    <= pix_d;
			col_q    <= col_d;
			bit_q    <= bit_d;
			half_q   <= half_d;
			lcnt_q   <= lcnt_d;
			idle_q   <= idle_d;
			clk_q    <= clk_d;
			dat_q    <= dat_d;
			status_q <= status_d;
			if (load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
			if (cmd.sweep) sweep_q <= sweep_q + PIX_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd) rd_q <= mem[pix_q[PIX_AW-1:0]];
	end

	// Line levels, status and sending only move on a load, so they double as
	// the result register while a result waits.
	assign rsp_valid      = out_valid_q;
	assign rsp_clock_line = clk_q;
	assign rsp_data_line  = dat_q;
	assign rsp_status     = status_q;
	assign rsp_sending    = fa_q;

	assign sts.frame_active = fa_q;
	assign sts.latch_phase  = lat_q;
	assign sts.half_phase   = half_q;
	assign sts.sweep_last   = (sweep_q == PIX_AW'(MAX_PIXELS - 1));
	assign sts.out_valid    = out_valid_q;

	a_latch_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		lat_q |-> fa_q)
		else $error("latch phase outside a frame");

	a_pix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fa_q && !lat_q) |-> (pix_q < LEN_W'(MAX_PIXELS)))
		else $error("pixel position past buffer while shifting");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_valid_q) |-> rsp_ready)
		else $error("result overwritten before it was taken");

	a_half_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> !clk_q)
		else $error("clock high in first half of a bit");

endmodule

[sv/rgb_led_strip_frame_sender.sv]
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_sender - RGB LED strip frame sender
// Frame buffer with a two-wire clock/data shift-out, APB configuration port.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Write, send, an idle tick, a latch-hold
// tick, a refused item and the second half of a bit go straight from
// acceptance into the result register. The first half of a bit passes first
// through a read state, since the pixel memory has a registered read port.
// Clear sweeps the valid flags of all 1024 pixel memory entries through its
// single write port, one entry a cycle, and then reaches the result register.
// The same clearing pass runs after reset, and no item is accepted during
// it. Configuration writes are taken at any time. A new item is accepted in
// the cycle a pending result is taken.
module rgb_led_strip_frame_sender (
	input  logic                         clk,
	input  logic                         arst_n,
	rlsf_req_if.sink                     req,
	rlsf_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rlsf_pkg::CFG_AW-1:0]  paddr,
	input  logic [rlsf_pkg::CFG_DW-1:0]  pwdata,
	output logic [rlsf_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready
);
	import rlsf_pkg::*;

	cfg_t cfg;
	logic refresh_wr;
	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign req.ready = ready;

	rlsf_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.refresh_wr (refresh_wr)
	);

	rlsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.req_ready (ready),
		.cmd       (cmd)
	);

	rlsf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.refresh_wr      (refresh_wr),
		.req_func        (req.func),
		.req_pixel_index (req.pixel_index),
		.req_red         (req.red),
		.req_green       (req.green),
		.req_blue        (req.blue),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_clock_line  (rsp.clock_line),
		.rsp_data_line   (rsp.data_line),
		.rsp_status      (rsp.status),
		.rsp_sending     (rsp.sending),
		.sts             (sts)
	);

endmodule
